/* rtl/core/efd_pkg.sv */
// Shared codes, widths and the CRC-16 byte update for the escaped frame deframer.
package efd_pkg;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned CRC_W   = 16;
    localparam int unsigned LEN_W   = 16;
    localparam int unsigned PHASE_W = 4;
    localparam int unsigned EVENT_W = 3;
    localparam int unsigned CFG_IDX_W = 2;

    typedef logic [BYTE_W-1:0]    t_byte;
    typedef logic [CRC_W-1:0]     t_crc;
    typedef logic [LEN_W-1:0]     t_len;
    typedef logic [PHASE_W-1:0]   t_phase;
    typedef logic [EVENT_W-1:0]   t_event;
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    // Frame phases
    localparam t_phase PH_HUNT    = 4'd0;
    localparam t_phase PH_LEN_HI  = 4'd1;
    localparam t_phase PH_LEN_LO  = 4'd2;
    localparam t_phase PH_SUB     = 4'd3;
    localparam t_phase PH_SEQ     = 4'd4;
    localparam t_phase PH_CMD     = 4'd5;
    localparam t_phase PH_PAYLOAD = 4'd6;
    localparam t_phase PH_CRC_HI  = 4'd7;
    localparam t_phase PH_CRC_LO  = 4'd8;

    // Result event codes
    localparam t_event EV_HEADER  = 3'd0;
    localparam t_event EV_DATA    = 3'd1;
    localparam t_event EV_GOOD    = 3'd2;
    localparam t_event EV_CRC_ERR = 3'd3;
    localparam t_event EV_SHORT   = 3'd4;
    localparam t_event EV_ABORT   = 3'd5;

    // Configuration register indexes
    localparam t_cfg_idx CFG_START_BYTE  = 2'd0;
    localparam t_cfg_idx CFG_ESCAPE_BYTE = 2'd1;
    localparam t_cfg_idx CFG_CRC_POLY    = 2'd2;
    localparam t_cfg_idx CFG_CRC_INIT    = 2'd3;

    // Reset values of the configuration registers
    localparam t_byte START_BYTE_RST  = 8'hFD;
    localparam t_byte ESCAPE_BYTE_RST = 8'hFC;
    localparam t_crc  CRC_POLY_RST    = 16'h8005;
    localparam t_crc  CRC_INIT_RST    = 16'hD77F;

    localparam t_byte ESC_MARK_BIT = 8'h80;
    localparam t_len  HDR_BYTES    = 16'd3;

    // MSB-first CRC-16 update over one byte, eight shift steps
    function automatic t_crc crc_byte(input t_crc crc, input t_byte data, input t_crc poly);
        t_crc c;
        c = crc ^ {data, 8'h00};
        for (int i = 0; i < BYTE_W; i++) begin
            if (c[CRC_W-1]) begin
                c = {c[CRC_W-2:0], 1'b0} ^ poly;
            end else begin
                c = {c[CRC_W-2:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

/* rtl/core/escaped_frame_deframer.sv */
// Byte-stuffed serial frame deframer with CRC-16 check, top level.
//
// Takes one raw received byte per word on the rx channel and streams out
// header, payload and status words on the event channel. Bytes are dropped
// until the start byte; inside a frame the escape byte is dropped and the
// following byte is taken with bit 7 set. A frame is a big-endian 16-bit
// length L, subsystem, sequence, opcode, L-3 payload bytes and two CRC bytes;
// the MSB-first CRC-16 (no final xor) runs from the initial value over every
// unescaped byte after the start byte and must end at zero. An unescaped
// start byte inside a frame aborts it (event 5) and opens a new frame.
// Timing: an rx word is captured in an input register, then decoded, CRC
// updated and any result loaded into the output register; one word per
// cycle is sustained while the event channel takes results without stall. The
// eight-step CRC update is combinational within the decode stage.
// A result left waiting in the output register holds the decode stage, so
// rx words stall behind it even when they owe no event.
// Configuration writes take effect at once and are meant for idle periods.
module escaped_frame_deframer
    import efd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration write port
    input  logic        i_cfg_wr_en,
    input  t_cfg_idx    i_cfg_index,
    input  logic [15:0] i_cfg_data,
    // rx byte channel
    input  logic        i_rx_valid,
    output logic        o_rx_ready,
    input  logic [7:0]  i_rx_byte,
    // event channel
    output logic        o_ev_valid,
    input  logic        i_ev_ready,
    output logic [2:0]  o_event_res,
    output logic [7:0]  o_data_byte,
    output logic [7:0]  o_subsystem,
    output logic [7:0]  o_sequence_res,
    output logic [7:0]  o_opcode,
    output logic [15:0] o_payload_length,
    output logic [15:0] o_byte_index
);

    // configuration
    t_byte  r_start_byte;
    t_byte  r_escape_byte;
    t_crc   r_crc_poly;
    t_crc   r_crc_init;

    // input register
    logic   r_in_vld;
    t_byte  r_in_byte;

    // frame state
    t_phase r_phase,    n_phase;
    logic   r_esc,      n_esc;
    t_crc   r_crc,      n_crc;
    t_len   r_flen,     n_flen;
    t_len   r_pcount,   n_pcount;
    t_byte  r_sub,      n_sub;
    t_byte  r_seq,      n_seq;
    t_byte  r_opc,      n_opc;

    // output register
    logic   r_out_vld;
    t_event r_ev,       n_ev;
    t_byte  r_data,     n_data;
    t_byte  r_o_sub,    n_o_sub;
    t_byte  r_o_seq,    n_o_seq;
    t_byte  r_o_opc,    n_o_opc;
    t_len   r_o_len,    n_o_len;
    t_len   r_o_idx,    n_o_idx;

    logic   w_adv;
    logic   w_emit;
    logic   w_use_old;
    logic   w_len_vld;
    t_byte  w_val;
    t_len   w_fl_emit;
    t_len   w_plen_new;

    function automatic t_len pay_len(input t_len fl);
        return (fl >= HDR_BYTES) ? t_len'(fl - HDR_BYTES) : '0;
    endfunction

    // advance the decode stage when the output register is free or draining
    assign w_adv      = r_in_vld && (!r_out_vld || i_ev_ready);
    assign o_rx_ready = !r_in_vld || w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_byte  <= START_BYTE_RST;
            r_escape_byte <= ESCAPE_BYTE_RST;
            r_crc_poly    <= CRC_POLY_RST;
            r_crc_init    <= CRC_INIT_RST;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CFG_START_BYTE:  r_start_byte  <= i_cfg_data[7:0];
                CFG_ESCAPE_BYTE: r_escape_byte <= i_cfg_data[7:0];
                CFG_CRC_POLY:    r_crc_poly    <= i_cfg_data;
                CFG_CRC_INIT:    r_crc_init    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        n_phase    = r_phase;
        n_esc      = r_esc;
        n_crc      = r_crc;
        n_flen     = r_flen;
        n_pcount   = r_pcount;
        n_sub      = r_sub;
        n_seq      = r_seq;
        n_opc      = r_opc;
        w_emit     = 1'b0;
        w_use_old  = 1'b0;
        w_len_vld  = 1'b1;
        n_ev       = EV_HEADER;
        n_data     = '0;
        n_o_idx    = '0;
        w_val      = r_esc ? (r_in_byte | ESC_MARK_BIT) : r_in_byte;
        w_plen_new = '0;

        if (w_adv) begin
            if (r_phase == PH_HUNT || r_phase > PH_CRC_LO) begin
                // hunt: drop everything up to the start byte
                if (r_in_byte == r_start_byte) begin
                    n_phase  = PH_LEN_HI;
                    n_esc    = 1'b0;
                    n_crc    = r_crc_init;
                    n_flen   = '0;
                    n_pcount = '0;
                    n_sub    = '0;
                    n_seq    = '0;
                    n_opc    = '0;
                end else begin
                    n_phase = PH_HUNT;
                end
            end else if (!r_esc && r_in_byte == r_start_byte) begin
                // abort: report the old frame, then open a new one
                w_emit    = 1'b1;
                w_use_old = 1'b1;
                w_len_vld = (r_phase > PH_LEN_LO);
                n_ev      = EV_ABORT;
                n_phase   = PH_LEN_HI;
                n_esc     = 1'b0;
                n_crc     = r_crc_init;
                n_flen    = '0;
                n_pcount  = '0;
                n_sub     = '0;
                n_seq     = '0;
                n_opc     = '0;
            end else if (!r_esc && r_in_byte == r_escape_byte) begin
                n_esc = 1'b1;
            end else begin
                n_esc = 1'b0;
                n_crc = crc_byte(r_crc, w_val, r_crc_poly);
                case (r_phase)
                    PH_LEN_HI: begin
                        n_flen  = {w_val, 8'h00};
                        n_phase = PH_LEN_LO;
                    end
                    PH_LEN_LO: begin
                        n_flen = {r_flen[15:8], w_val};
                        if (n_flen < HDR_BYTES) begin
                            w_emit  = 1'b1;
                            n_ev    = EV_SHORT;
                            n_phase = PH_HUNT;
                        end else begin
                            n_phase = PH_SUB;
                        end
                    end
                    PH_SUB: begin
                        n_sub   = w_val;
                        n_phase = PH_SEQ;
                    end
                    PH_SEQ: begin
                        n_seq   = w_val;
                        n_phase = PH_CMD;
                    end
                    PH_CMD: begin
                        n_opc    = w_val;
                        n_pcount = '0;
                        w_emit   = 1'b1;
                        n_ev     = EV_HEADER;
                        n_phase  = (pay_len(r_flen) != '0) ? PH_PAYLOAD : PH_CRC_HI;
                    end
                    PH_PAYLOAD: begin
                        w_emit   = 1'b1;
                        n_ev     = EV_DATA;
                        n_data   = w_val;
                        n_o_idx  = r_pcount;
                        n_pcount = r_pcount + 16'd1;
                        if (n_pcount >= pay_len(r_flen)) begin
                            n_phase = PH_CRC_HI;
                        end
                    end
                    PH_CRC_HI: begin
                        n_phase = PH_CRC_LO;
                    end
                    default: begin
                        // last CRC byte: residue must be zero
                        w_emit  = 1'b1;
                        n_ev    = (n_crc == '0) ? EV_GOOD : EV_CRC_ERR;
                        n_phase = PH_HUNT;
                    end
                endcase
            end
        end

        // abort reports the fields held before the restart
        w_fl_emit  = w_use_old ? r_flen : n_flen;
        w_plen_new = pay_len(w_fl_emit);
        n_o_sub    = w_use_old ? r_sub : n_sub;
        n_o_seq    = w_use_old ? r_seq : n_seq;
        n_o_opc    = w_use_old ? r_opc : n_opc;
        n_o_len    = w_len_vld ? w_plen_new : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            r_phase   <= PH_HUNT;
            r_esc     <= 1'b0;
            r_crc     <= '0;
            r_flen    <= '0;
            r_pcount  <= '0;
            r_sub     <= '0;
            r_seq     <= '0;
            r_opc     <= '0;
        end else begin
            if (o_rx_ready) begin
                r_in_vld <= i_rx_valid;
            end
            // hold a result until taken, load a new one when the stage emits
            if (w_emit) begin
                r_out_vld <= 1'b1;
            end else if (i_ev_ready) begin
                r_out_vld <= 1'b0;
            end
            r_phase  <= n_phase;
            r_esc    <= n_esc;
            r_crc    <= n_crc;
            r_flen   <= n_flen;
            r_pcount <= n_pcount;
            r_sub    <= n_sub;
            r_seq    <= n_seq;
            r_opc    <= n_opc;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (o_rx_ready && i_rx_valid) begin
            r_in_byte <= i_rx_byte;
        end
        if (w_emit) begin
            r_ev    <= n_ev;
            r_data  <= n_data;
            r_o_sub <= n_o_sub;
            r_o_seq <= n_o_seq;
            r_o_opc <= n_o_opc;
            r_o_len <= n_o_len;
            r_o_idx <= n_o_idx;
        end
    end

    assign o_ev_valid       = r_out_vld;
    assign o_event_res      = r_ev;
    assign o_data_byte      = r_data;
    assign o_subsystem      = r_o_sub;
    assign o_sequence_res   = r_o_seq;
    assign o_opcode         = r_o_opc;
    assign o_payload_length = r_o_len;
    assign o_byte_index     = r_o_idx;

endmodule
